FILE: src/azc_pkg.sv
package azc_pkg;

  // zone slots carried in the masks and result fields
  localparam int unsigned ZONE_SLOTS     = 6;
  localparam int unsigned NUM_ZONES_DEF  = 6;

  // entry delays: three 10-bit fields per 30-bit register
  localparam int unsigned DELAY_W        = 10;
  localparam int unsigned ZONES_PER_WORD = 3;
  localparam int unsigned DELAY_WORD_W   = DELAY_W * ZONES_PER_WORD;
  localparam int unsigned CNT_W          = DELAY_W + 1;

  localparam int unsigned MODE_W         = 3;
  localparam int unsigned STATE_W        = 2;
  localparam int unsigned STATES_W       = STATE_W * ZONE_SLOTS;

  // stream payload layout
  localparam int unsigned IN_TDATA_W     = 16;
  localparam int unsigned OUT_TDATA_W    = 32;
  localparam int unsigned IN_ZONES_LSB   = 0;
  localparam int unsigned IN_TAMPER_BIT  = ZONE_SLOTS;
  localparam int unsigned IN_MODE_LSB    = ZONE_SLOTS + 1;

  localparam int unsigned OUT_ALERT_LSB  = STATES_W;
  localparam int unsigned OUT_NEWLY_LSB  = STATES_W + ZONE_SLOTS;
  localparam int unsigned OUT_ALARM_BIT  = STATES_W + 2 * ZONE_SLOTS;
  localparam int unsigned OUT_TAMPER_BIT = OUT_ALARM_BIT + 1;
  localparam int unsigned OUT_RAISED_BIT = OUT_ALARM_BIT + 2;

  // configuration port
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = DELAY_WORD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARMED    = 3'd0,
    REG_TRIGGER  = 3'd1,
    REG_NIGHT    = 3'd2,
    REG_DELAY_LO = 3'd3,
    REG_DELAY_HI = 3'd4
  } cfg_reg_t;

  localparam logic [ZONE_SLOTS-1:0]   ARMED_RST   = 6'd63;
  localparam logic [ZONE_SLOTS-1:0]   TRIGGER_RST = 6'd56;
  localparam logic [ZONE_SLOTS-1:0]   NIGHT_RST   = 6'd56;
  localparam logic [DELAY_WORD_W-1:0] DELAY_RST   = 30'd2099202;

  localparam logic [MODE_W-1:0] MODE_NIGHT = 3'd0;

  typedef enum logic [STATE_W-1:0] {
    ZS_NORMAL    = 2'd0,
    ZS_SENSED    = 2'd1,
    ZS_TRIGGERED = 2'd2,
    ZS_EXIT_WAIT = 2'd3
  } zone_state_t;

endpackage

FILE: src/alarm_zone_controller.sv
// A result item is registered and shown in the cycle after its input is taken.
// Throughput: one item per cycle while results are taken; all zone machines step
// in parallel, and a new item is let in while the previous result is taken.
// Reset (rst, synchronous): all zones normal, counters zero, alarm and tamper
// latches clear, registers at their defaults, no result pending.
module alarm_zone_controller #(
  parameter int unsigned NUM_ZONES = azc_pkg::NUM_ZONES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [azc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [azc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // from bit 0: zone_inputs[5:0], tamper, panel_mode[2:0], zero fill
  input  logic [azc_pkg::IN_TDATA_W-1:0]      s_tdata,
  // action
  input  logic                                s_tuser,
  // result items
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // from bit 0: zone_states[11:0], alert_mask[5:0], newly_sensed_mask[5:0],
  // alarm_active, tamper_latched, alarm_raised, zero fill
  output logic [azc_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  // configuration registers
  logic [azc_pkg::ZONE_SLOTS-1:0]   armed_mask;
  logic [azc_pkg::ZONE_SLOTS-1:0]   trigger_mask;
  logic [azc_pkg::ZONE_SLOTS-1:0]   night_mask;
  logic [azc_pkg::DELAY_WORD_W-1:0] delay_lo;
  logic [azc_pkg::DELAY_WORD_W-1:0] delay_hi;

  // zone and panel state
  azc_pkg::zone_state_t             zone_st [NUM_ZONES];
  azc_pkg::zone_state_t             zone_st_next [NUM_ZONES];
  logic [azc_pkg::CNT_W-1:0]        zone_cnt [NUM_ZONES];
  logic [azc_pkg::CNT_W-1:0]        zone_cnt_next [NUM_ZONES];
  logic [NUM_ZONES-1:0]             newly;
  logic [NUM_ZONES-1:0]             trig;
  logic                             tamper_flag;
  logic                             tamper_flag_next;
  logic                             alarm_flag;
  logic                             alarm_flag_next;
  logic                             tamper_hit;

  // input item fields
  logic                             in_accept;
  logic                             action;
  logic [azc_pkg::ZONE_SLOTS-1:0]   zone_in;
  logic                             tamper_in;
  logic [azc_pkg::MODE_W-1:0]       mode_in;
  logic                             mode_is_night;

  // result fields
  logic [azc_pkg::STATES_W-1:0]     states_out;
  logic [azc_pkg::ZONE_SLOTS-1:0]   alert_out;
  logic [azc_pkg::ZONE_SLOTS-1:0]   newly_out;
  logic [azc_pkg::OUT_TDATA_W-1:0]  result;

  assign cfg_ready  = 1'b1;
  assign s_tready   = !m_tvalid || m_tready;
  assign in_accept  = s_tvalid && s_tready;

  assign action        = s_tuser;
  assign zone_in       = s_tdata[azc_pkg::IN_ZONES_LSB +: azc_pkg::ZONE_SLOTS];
  assign tamper_in     = s_tdata[azc_pkg::IN_TAMPER_BIT];
  assign mode_in       = s_tdata[azc_pkg::IN_MODE_LSB +: azc_pkg::MODE_W];
  assign mode_is_night = (mode_in == azc_pkg::MODE_NIGHT);

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      armed_mask   <= azc_pkg::ARMED_RST;
      trigger_mask <= azc_pkg::TRIGGER_RST;
      night_mask   <= azc_pkg::NIGHT_RST;
      delay_lo     <= azc_pkg::DELAY_RST;
      delay_hi     <= azc_pkg::DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        azc_pkg::REG_ARMED:    armed_mask   <= cfg_data[azc_pkg::ZONE_SLOTS-1:0];
        azc_pkg::REG_TRIGGER:  trigger_mask <= cfg_data[azc_pkg::ZONE_SLOTS-1:0];
        azc_pkg::REG_NIGHT:    night_mask   <= cfg_data[azc_pkg::ZONE_SLOTS-1:0];
        azc_pkg::REG_DELAY_LO: delay_lo     <= cfg_data;
        azc_pkg::REG_DELAY_HI: delay_hi     <= cfg_data;
        default: ;
      endcase
    end
  end

  // one machine per zone
  for (genvar z = 0; z < NUM_ZONES; z++) begin : g_zone
    localparam int unsigned SH = (z % azc_pkg::ZONES_PER_WORD) * azc_pkg::DELAY_W;
    logic [azc_pkg::DELAY_W-1:0] dly;
    logic [azc_pkg::CNT_W-1:0]   cnt_inc;
    logic                        armed;
    logic                        night;

    assign dly     = (z < azc_pkg::ZONES_PER_WORD) ? delay_lo[SH +: azc_pkg::DELAY_W]
                                                    : delay_hi[SH +: azc_pkg::DELAY_W];
    assign cnt_inc = zone_cnt[z] + 1'b1;
    assign armed   = armed_mask[z];
    assign night   = night_mask[z];

    always_comb begin
      zone_st_next[z]  = zone_st[z];
      zone_cnt_next[z] = zone_cnt[z];
      newly[z]         = 1'b0;
      trig[z]          = 1'b0;
      if (action) begin
        // stop: clear counter, armed night zones go to exit wait in night mode
        zone_cnt_next[z] = '0;
        zone_st_next[z]  = (mode_is_night && armed && night) ? azc_pkg::ZS_EXIT_WAIT
                                                             : azc_pkg::ZS_NORMAL;
      end else begin
        unique case (zone_st[z])
          azc_pkg::ZS_NORMAL: begin
            if (armed && (!night || mode_is_night) &&
                (zone_in[z] == trigger_mask[z])) begin
              zone_st_next[z] = azc_pkg::ZS_SENSED;
              newly[z]        = 1'b1;
            end
          end
          azc_pkg::ZS_SENSED: begin
            zone_cnt_next[z] = cnt_inc;
            if (cnt_inc > {1'b0, dly}) begin
              zone_cnt_next[z] = '0;
              zone_st_next[z]  = azc_pkg::ZS_TRIGGERED;
              trig[z]          = 1'b1;
            end
          end
          azc_pkg::ZS_EXIT_WAIT: begin
            zone_cnt_next[z] = cnt_inc;
            if (cnt_inc > {1'b0, dly}) begin
              zone_cnt_next[z] = '0;
              zone_st_next[z]  = azc_pkg::ZS_NORMAL;
            end
          end
          azc_pkg::ZS_TRIGGERED: ;
          default: ;
        endcase
      end
    end

    // hold zone state between items
    always_ff @(posedge clk) begin
      if (rst) begin
        zone_st[z]  <= azc_pkg::ZS_NORMAL;
        zone_cnt[z] <= '0;
      end else if (in_accept) begin
        zone_st[z]  <= zone_st_next[z];
        zone_cnt[z] <= zone_cnt_next[z];
      end
    end
  end

  // tamper latch and alarm flag
  assign tamper_hit       = !action && tamper_in && !tamper_flag;
  assign tamper_flag_next = action ? 1'b0 : (tamper_flag || tamper_in);
  assign alarm_flag_next  = action ? 1'b0 : (alarm_flag || (|trig) || tamper_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      tamper_flag <= 1'b0;
      alarm_flag  <= 1'b0;
    end else if (in_accept) begin
      tamper_flag <= tamper_flag_next;
      alarm_flag  <= alarm_flag_next;
    end
  end

  // pack the result, unused zone slots read as normal
  always_comb begin
    states_out = '0;
    alert_out  = '0;
    newly_out  = '0;
    for (int i = 0; i < NUM_ZONES; i++) begin
      states_out[azc_pkg::STATE_W*i +: azc_pkg::STATE_W] = zone_st_next[i];
      alert_out[i] = (zone_st_next[i] == azc_pkg::ZS_SENSED) ||
                     (zone_st_next[i] == azc_pkg::ZS_TRIGGERED);
      newly_out[i] = newly[i];
    end
    result = '0;
    result[0 +: azc_pkg::STATES_W]                       = states_out;
    result[azc_pkg::OUT_ALERT_LSB +: azc_pkg::ZONE_SLOTS] = alert_out;
    result[azc_pkg::OUT_NEWLY_LSB +: azc_pkg::ZONE_SLOTS] = newly_out;
    result[azc_pkg::OUT_ALARM_BIT]                       = alarm_flag_next;
    result[azc_pkg::OUT_TAMPER_BIT]                      = tamper_flag_next;
    result[azc_pkg::OUT_RAISED_BIT]                      = (|trig) || tamper_hit;
  end

  // result register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_tdata <= result;
    end
  end

endmodule

FILE: src/azc_chk.sv
module azc_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [azc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic [azc_pkg::ZONE_SLOTS-1:0] alert;
  logic [azc_pkg::ZONE_SLOTS-1:0] newly;
  logic [azc_pkg::ZONE_SLOTS-1:0] alert_from_states;

  assign alert = m_tdata[azc_pkg::OUT_ALERT_LSB +: azc_pkg::ZONE_SLOTS];
  assign newly = m_tdata[azc_pkg::OUT_NEWLY_LSB +: azc_pkg::ZONE_SLOTS];

  // sensed (1) and triggered (2) are the codes whose two bits differ
  assign alert_from_states = {m_tdata[11] ^ m_tdata[10], m_tdata[9] ^ m_tdata[8],
                              m_tdata[7] ^ m_tdata[6],   m_tdata[5] ^ m_tdata[4],
                              m_tdata[3] ^ m_tdata[2],   m_tdata[1] ^ m_tdata[0]};

  // a stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // every accepted item yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item gave no result");

  // a stop item clears alarm, tamper and pulses
  a_stop: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=>
      !m_tdata[azc_pkg::OUT_ALARM_BIT] && !m_tdata[azc_pkg::OUT_TAMPER_BIT] &&
      !m_tdata[azc_pkg::OUT_RAISED_BIT] && (newly == '0))
    else $error("stop item left alarm or pulses set");

  // alert mask follows the zone states
  a_alert: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> alert == alert_from_states)
    else $error("alert mask disagrees with zone states");

  // a raised alarm is active in the same item
  a_raised: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[azc_pkg::OUT_RAISED_BIT] |-> m_tdata[azc_pkg::OUT_ALARM_BIT])
    else $error("alarm raised but not active");

endmodule

bind alarm_zone_controller azc_chk u_azc_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: bench/tb_alarm_zone_controller.sv
`timescale 1ns / 100ps

module tb_alarm_zone_controller;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_STOP = 1'b1;

  localparam logic [azc_pkg::MODE_W-1:0] MODE_DAY        = 3'd1;
  localparam logic [azc_pkg::MODE_W-1:0] MODE_DISARMED   = 3'd2;
  localparam logic [azc_pkg::MODE_W-1:0] MODE_BYPASS     = 3'd3;
  localparam logic [azc_pkg::MODE_W-1:0] MODE_NIGHT_WAIT = 3'd4;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int N_SEGMENTS  = 8;
  localparam int SEG_ITEMS   = 91;
  localparam int N_DIR       = 22;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic                       action;
    logic [5:0]                 zones;
    logic                       tamper;
    logic [azc_pkg::MODE_W-1:0] mode;
  } azc_item_t;

  typedef struct packed {
    logic [azc_pkg::STATES_W-1:0]   states;
    logic [azc_pkg::ZONE_SLOTS-1:0] alert;
    logic [azc_pkg::ZONE_SLOTS-1:0] newly;
    logic                           alarm;
    logic                           tamper;
    logic                           raised;
  } azc_status_t;

  typedef struct packed {
    azc_item_t   item;
    logic        typed;
    azc_status_t want;
  } dir_row_t;

  localparam azc_status_t ST_ANY = '0;

  logic                            clk;
  logic                            rst;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [azc_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [azc_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [azc_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic                            s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [azc_pkg::OUT_TDATA_W-1:0] m_tdata;

  alarm_zone_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Directed rows, starting from the reset settings (zones 0-2 day, alarm at 0;
  // zones 3-5 night, alarm at 1; every delay field 2)
  dir_row_t dir_tab [N_DIR] = '{
    '{'{ACT_TICK, 6'b000111, 1'b0, MODE_DAY},        1'b1,
      '{12'h000, 6'h00, 6'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_TICK, 6'b111000, 1'b0, MODE_DAY},        1'b1,
      '{12'h015, 6'h07, 6'h07, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_TICK, 6'b111111, 1'b0, MODE_DAY},        1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b111111, 1'b0, MODE_DAY},        1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b111111, 1'b0, MODE_DAY},        1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b000000, 1'b1, MODE_BYPASS},     1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b000000, 1'b1, MODE_BYPASS},     1'b0, ST_ANY},
    '{'{ACT_STOP, 6'b111111, 1'b1, azc_pkg::MODE_NIGHT}, 1'b1,
      '{12'hFC0, 6'h00, 6'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_TICK, 6'b000111, 1'b0, azc_pkg::MODE_NIGHT}, 1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b000111, 1'b0, azc_pkg::MODE_NIGHT}, 1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b000111, 1'b0, azc_pkg::MODE_NIGHT}, 1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b111000, 1'b0, azc_pkg::MODE_NIGHT}, 1'b0, ST_ANY},
    '{'{ACT_STOP, 6'b111111, 1'b1, MODE_NIGHT_WAIT}, 1'b1,
      '{12'h000, 6'h00, 6'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_TICK, 6'b111111, 1'b1, MODE_NIGHT_WAIT}, 1'b1,
      '{12'h000, 6'h00, 6'h00, 1'b1, 1'b1, 1'b1}},
    '{'{ACT_TICK, 6'b111000, 1'b0, MODE_DISARMED},   1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b111000, 1'b0, MODE_DISARMED},   1'b0, ST_ANY},
    '{'{ACT_STOP, 6'b000000, 1'b0, MODE_DAY},        1'b1,
      '{12'h000, 6'h00, 6'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ACT_TICK, 6'b111000, 1'b0, azc_pkg::MODE_NIGHT}, 1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b000000, 1'b0, azc_pkg::MODE_NIGHT}, 1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b000000, 1'b0, azc_pkg::MODE_NIGHT}, 1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b000000, 1'b0, azc_pkg::MODE_NIGHT}, 1'b0, ST_ANY},
    '{'{ACT_TICK, 6'b000000, 1'b1, azc_pkg::MODE_NIGHT}, 1'b0, ST_ANY}
  };

  // Zone model state and its copy of the registers
  azc_pkg::zone_state_t             zone_st  [azc_pkg::ZONE_SLOTS];
  logic [azc_pkg::CNT_W-1:0]        zone_cnt [azc_pkg::ZONE_SLOTS];
  logic                             tamper_seen;
  logic                             alarm_on;
  logic [azc_pkg::ZONE_SLOTS-1:0]   armed_bits;
  logic [azc_pkg::ZONE_SLOTS-1:0]   level_bits;
  logic [azc_pkg::ZONE_SLOTS-1:0]   night_bits;
  logic [azc_pkg::DELAY_WORD_W-1:0] delay_lo;
  logic [azc_pkg::DELAY_WORD_W-1:0] delay_hi;

  azc_status_t status_q [$];

  // Driver-side side band for typed rows
  logic        row_typed;
  azc_status_t row_want;

  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold_req;
  int idle_cycles;
  int n_err;
  int n_in;
  int n_out;
  int n_stops;
  int n_raised;
  int n_writes;

  task automatic clear_zone_model();
    for (int z = 0; z < azc_pkg::ZONE_SLOTS; z++) begin
      zone_st[z]  = azc_pkg::ZS_NORMAL;
      zone_cnt[z] = '0;
    end
    tamper_seen = 1'b0;
    alarm_on    = 1'b0;
    armed_bits  = azc_pkg::ARMED_RST;
    level_bits  = azc_pkg::TRIGGER_RST;
    night_bits  = azc_pkg::NIGHT_RST;
    delay_lo    = azc_pkg::DELAY_RST;
    delay_hi    = azc_pkg::DELAY_RST;
  endtask

  // Step every zone machine for one item and return the panel status after it
  function automatic azc_status_t advance_zones(input azc_item_t it);
    azc_status_t r;
    logic [azc_pkg::DELAY_W-1:0] dly;
    logic armed;
    logic night;
    r = '0;
    for (int z = 0; z < azc_pkg::ZONE_SLOTS; z++) begin
      armed = armed_bits[z];
      night = night_bits[z];
      if (z < azc_pkg::ZONES_PER_WORD)
        dly = delay_lo[(z % azc_pkg::ZONES_PER_WORD) * azc_pkg::DELAY_W +: azc_pkg::DELAY_W];
      else
        dly = delay_hi[(z % azc_pkg::ZONES_PER_WORD) * azc_pkg::DELAY_W +: azc_pkg::DELAY_W];
      if (it.action == ACT_STOP) begin
        zone_cnt[z] = '0;
        if (it.mode == azc_pkg::MODE_NIGHT && armed && night)
          zone_st[z] = azc_pkg::ZS_EXIT_WAIT;
        else
          zone_st[z] = azc_pkg::ZS_NORMAL;
      end else begin
        case (zone_st[z])
          azc_pkg::ZS_NORMAL: begin
            if (armed && (!night || it.mode == azc_pkg::MODE_NIGHT) &&
                it.zones[z] == level_bits[z]) begin
              zone_st[z] = azc_pkg::ZS_SENSED;
              r.newly[z] = 1'b1;
            end
          end
          azc_pkg::ZS_SENSED: begin
            zone_cnt[z] = zone_cnt[z] + 1'b1;
            if (zone_cnt[z] > {1'b0, dly}) begin
              zone_cnt[z] = '0;
              zone_st[z]  = azc_pkg::ZS_TRIGGERED;
              alarm_on    = 1'b1;
              r.raised    = 1'b1;
            end
          end
          azc_pkg::ZS_EXIT_WAIT: begin
            zone_cnt[z] = zone_cnt[z] + 1'b1;
            if (zone_cnt[z] > {1'b0, dly}) begin
              zone_cnt[z] = '0;
              zone_st[z]  = azc_pkg::ZS_NORMAL;
            end
          end
          default: ;
        endcase
      end
    end
    // tamper raises the alarm once per stop
    if (it.action == ACT_STOP) begin
      tamper_seen = 1'b0;
      alarm_on    = 1'b0;
    end else if (it.tamper && !tamper_seen) begin
      tamper_seen = 1'b1;
      alarm_on    = 1'b1;
      r.raised    = 1'b1;
    end
    for (int z = 0; z < azc_pkg::ZONE_SLOTS; z++) begin
      r.states[azc_pkg::STATE_W*z +: azc_pkg::STATE_W] = zone_st[z];
      r.alert[z] = (zone_st[z] == azc_pkg::ZS_SENSED) ||
                   (zone_st[z] == azc_pkg::ZS_TRIGGERED);
    end
    r.alarm  = alarm_on;
    r.tamper = tamper_seen;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_err++;
    if (n_err <= MAX_PRINTS)
      $display("tb: result %0d %s mismatch: got 0x%0h, want 0x%0h", n_out, what, got, want);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Observe handshakes: track registers, predict, check, watch for hangs
  always @(posedge clk) begin : observe
    azc_item_t   seen;
    azc_status_t want;
    azc_status_t got;
    azc_status_t pred;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (cfg_index)
          azc_pkg::REG_ARMED:    armed_bits = cfg_data[azc_pkg::ZONE_SLOTS-1:0];
          azc_pkg::REG_TRIGGER:  level_bits = cfg_data[azc_pkg::ZONE_SLOTS-1:0];
          azc_pkg::REG_NIGHT:    night_bits = cfg_data[azc_pkg::ZONE_SLOTS-1:0];
          azc_pkg::REG_DELAY_LO: delay_lo   = cfg_data[azc_pkg::DELAY_WORD_W-1:0];
          azc_pkg::REG_DELAY_HI: delay_hi   = cfg_data[azc_pkg::DELAY_WORD_W-1:0];
          default: ;
        endcase
      end
      // check the oldest expectation before queuing this edge's item
      if (m_tvalid && m_tready) begin
        n_out++;
        got.states = m_tdata[0 +: azc_pkg::STATES_W];
        got.alert  = m_tdata[azc_pkg::OUT_ALERT_LSB +: azc_pkg::ZONE_SLOTS];
        got.newly  = m_tdata[azc_pkg::OUT_NEWLY_LSB +: azc_pkg::ZONE_SLOTS];
        got.alarm  = m_tdata[azc_pkg::OUT_ALARM_BIT];
        got.tamper = m_tdata[azc_pkg::OUT_TAMPER_BIT];
        got.raised = m_tdata[azc_pkg::OUT_RAISED_BIT];
        if (got.raised)
          n_raised++;
        if (status_q.size() == 0) begin
          report_mismatch("unexpected", m_tdata, 32'd0);
        end else begin
          want = status_q.pop_front();
          if (got.states !== want.states)
            report_mismatch("zone_states", 32'(got.states), 32'(want.states));
          if (got.alert !== want.alert)
            report_mismatch("alert_mask", 32'(got.alert), 32'(want.alert));
          if (got.newly !== want.newly)
            report_mismatch("newly_sensed_mask", 32'(got.newly), 32'(want.newly));
          if (got.alarm !== want.alarm)
            report_mismatch("alarm_active", 32'(got.alarm), 32'(want.alarm));
          if (got.tamper !== want.tamper)
            report_mismatch("tamper_latched", 32'(got.tamper), 32'(want.tamper));
          if (got.raised !== want.raised)
            report_mismatch("alarm_raised", 32'(got.raised), 32'(want.raised));
          if (m_tdata[azc_pkg::OUT_TDATA_W-1:azc_pkg::OUT_RAISED_BIT+1] !== '0)
            report_mismatch("zero fill", m_tdata, 32'd0);
        end
      end
      if (s_tvalid && s_tready) begin
        n_in++;
        seen.action = s_tuser;
        seen.zones  = s_tdata[azc_pkg::IN_ZONES_LSB +: azc_pkg::ZONE_SLOTS];
        seen.tamper = s_tdata[azc_pkg::IN_TAMPER_BIT];
        seen.mode   = s_tdata[azc_pkg::IN_MODE_LSB +: azc_pkg::MODE_W];
        if (seen.action == ACT_STOP)
          n_stops++;
        pred = advance_zones(seen);
        status_q.push_back(row_typed ? row_want : pred);
      end
      // hang detection
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, status_q.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold until taken
  task automatic offer_item(input azc_item_t it, input logic typed, input azc_status_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid  = 1'b1;
    s_tuser   = it.action;
    s_tdata   = {{(azc_pkg::IN_TDATA_W - azc_pkg::IN_MODE_LSB - azc_pkg::MODE_W){1'b0}},
                 it.mode, it.tamper, it.zones};
    row_typed = typed;
    row_want  = want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait for every expected result
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input azc_pkg::cfg_reg_t idx,
                           input logic [azc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly short delays so zones reach triggered, now and then a long one
  function automatic logic [azc_pkg::DELAY_WORD_W-1:0] pick_delays();
    logic [azc_pkg::DELAY_WORD_W-1:0] w;
    for (int k = 0; k < azc_pkg::ZONES_PER_WORD; k++) begin
      if ($urandom_range(0, 99) < 10)
        w[k*azc_pkg::DELAY_W +: azc_pkg::DELAY_W] =
          azc_pkg::DELAY_W'($urandom_range(0, 1023));
      else
        w[k*azc_pkg::DELAY_W +: azc_pkg::DELAY_W] =
          azc_pkg::DELAY_W'($urandom_range(0, 6));
    end
    return w;
  endfunction

  initial begin : stimulus
    azc_item_t it;
    logic [azc_pkg::MODE_W-1:0] cur_mode;
    logic [azc_pkg::ZONE_SLOTS-1:0] arm_v;
    logic [azc_pkg::ZONE_SLOTS-1:0] lvl_v;
    logic [azc_pkg::ZONE_SLOTS-1:0] ngt_v;
    logic [azc_pkg::DELAY_WORD_W-1:0] lo_v;
    logic [azc_pkg::DELAY_WORD_W-1:0] hi_v;

    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = azc_pkg::REG_ARMED;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = ACT_TICK;
    row_typed   = 1'b0;
    row_want    = ST_ANY;
    rx_hold_req = 1'b0;
    idle_cycles = 0;
    n_err       = 0;
    n_in        = 0;
    n_out       = 0;
    n_stops     = 0;
    n_raised    = 0;
    n_writes    = 0;
    tx_idle_pct = 34;
    rx_idle_pct = 86;
    clear_zone_model();
    cur_mode = azc_pkg::MODE_NIGHT;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows from the reset settings
    for (int i = 0; i < N_DIR; i++)
      offer_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    // random segments, each under its own register settings
    for (int seg = 0; seg < N_SEGMENTS; seg++) begin
      if (seg == 3) begin
        tx_idle_pct = 86;
        rx_idle_pct = 34;
      end else if (seg == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      wait_drained();
      case (seg)
        0: begin
          arm_v = '1; lvl_v = '0; ngt_v = '0; lo_v = '0; hi_v = '0;
        end
        1: begin
          arm_v = '0; lvl_v = '1; ngt_v = '1; lo_v = '1; hi_v = '1;
        end
        6: begin
          arm_v = azc_pkg::ARMED_RST; lvl_v = azc_pkg::TRIGGER_RST;
          ngt_v = azc_pkg::NIGHT_RST;
          lo_v = azc_pkg::DELAY_RST; hi_v = azc_pkg::DELAY_RST;
        end
        default: begin
          arm_v = azc_pkg::ZONE_SLOTS'($urandom);
          lvl_v = azc_pkg::ZONE_SLOTS'($urandom);
          ngt_v = azc_pkg::ZONE_SLOTS'($urandom);
          lo_v  = pick_delays();
          hi_v  = pick_delays();
        end
      endcase
      write_reg(azc_pkg::REG_ARMED,    azc_pkg::CFG_DATA_W'(arm_v));
      write_reg(azc_pkg::REG_TRIGGER,  azc_pkg::CFG_DATA_W'(lvl_v));
      write_reg(azc_pkg::REG_NIGHT,    azc_pkg::CFG_DATA_W'(ngt_v));
      write_reg(azc_pkg::REG_DELAY_LO, lo_v);
      write_reg(azc_pkg::REG_DELAY_HI, hi_v);

      for (int i = 0; i < SEG_ITEMS; i++) begin
        // let the panel mode persist so zones get time to count
        if ($urandom_range(0, 99) < 12) begin
          if ($urandom_range(0, 99) < 45)
            cur_mode = azc_pkg::MODE_NIGHT;
          else
            cur_mode = azc_pkg::MODE_W'($urandom_range(1, 4));
        end
        it.action = ($urandom_range(0, 99) < 5) ? ACT_STOP : ACT_TICK;
        it.zones  = azc_pkg::ZONE_SLOTS'($urandom);
        it.tamper = ($urandom_range(0, 99) < 8);
        it.mode   = cur_mode;
        // back up the result side while items keep coming
        if (seg == 1 && i == 30)
          rx_hold_req = 1'b1;
        offer_item(it, 1'b0, ST_ANY);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);

    $display("tb: %0d items sent (%0d stops), %0d results checked, %0d alarm raises",
             n_in, n_stops, n_out, n_raised);
    $display("tb: %0d register writes over %0d settings, three stall profiles",
             n_writes, N_SEGMENTS);
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", n_err);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/azc_pkg.sv
src/alarm_zone_controller.sv
src/azc_chk.sv
bench/tb_alarm_zone_controller.sv
